FILE: rtl/scdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_pkg
// Shared types and constants of the spectral convolution/deconvolution block.
// ----------------------------------------------------------------------------
package scdt_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 24;
  localparam int OUT_W  = 32;
  localparam int THR_W  = 16;
  localparam int MAG_W  = 48;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic MODE_MUL = 1'b0;
  localparam logic MODE_DIV = 1'b1;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_MODE      = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]         bin_index;
    logic signed [DATA_W-1:0] in_re;
    logic signed [DATA_W-1:0] in_im;
    logic signed [DATA_W-1:0] kern_re;
    logic signed [DATA_W-1:0] kern_im;
    logic                     kind;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        res_index;
    logic signed [OUT_W-1:0] out_re;
    logic signed [OUT_W-1:0] out_im;
    logic                    gated;
    logic                    clipped;
  } out_item_t;

  // front -> back queue entry: one read request, operands already fetched
  typedef struct packed {
    logic [IDX_W-1:0]         res_index;
    logic                     pass;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
    logic [MAG_W-1:0]         mag;
  } job_t;

endpackage

FILE: rtl/scdt_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface scdt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/scdt_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scdt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/scdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scdt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/scdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_front
// Accepts requests, stores loads, tracks the kernel peak, fetches read
// operands and evaluates the gate, then hands read jobs to the queue.
// ----------------------------------------------------------------------------
module scdt_front #(
  parameter int BINS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  scdt_pkg::in_item_t          in_data,
  input  logic [scdt_pkg::THR_W-1:0]  threshold,
  output logic                        job_valid,
  input  logic                        job_ready,
  output scdt_pkg::job_t              job_data
);
  import scdt_pkg::*;

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAG  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_THR  = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]   state_r, state_nxt;
  in_item_t     req_r;
  logic         in_range_r;
  logic [MAG_W-1:0] peak_r;
  logic [MAG_W-1:0] sq_re_r, sq_im_r, mag_r;
  logic [MAG_W-1:0] mag_sum;
  logic [31:0]      thr_sq_r;
  logic [55:0]      rhs_hi_r;
  logic [79:0]      rhs_r;

  logic           we;
  logic [AW-1:0]  addr;
  logic [2*DATA_W-1:0] sig_rd, ker_rd;
  logic signed [DATA_W-1:0] kr, ki;

  assign in_ready  = (state_r == ST_IDLE);
  assign we        = in_valid && in_ready && in_data.kind == KIND_LOAD &&
                     ({{(32-IDX_W){1'b0}}, in_data.bin_index} < 32'(BINS));
  assign addr      = (state_r == ST_IDLE) ? AW'(in_data.bin_index)
                                          : AW'(req_r.bin_index);

  scdt_ram #(.WIDTH(2*DATA_W), .DEPTH(BINS)) u_sig (
    .clk(clk), .we(we), .addr(addr), .wdata({in_data.in_re, in_data.in_im}),
    .rdata(sig_rd));
  scdt_ram #(.WIDTH(2*DATA_W), .DEPTH(BINS)) u_ker (
    .clk(clk), .we(we), .addr(addr), .wdata({in_data.kern_re, in_data.kern_im}),
    .rdata(ker_rd));

  assign kr = (req_r.kind == KIND_LOAD) ? req_r.kern_re : $signed(ker_rd[2*DATA_W-1:DATA_W]);
  assign ki = (req_r.kind == KIND_LOAD) ? req_r.kern_im : $signed(ker_rd[DATA_W-1:0]);

  assign mag_sum = sq_re_r + sq_im_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        state_nxt = (in_data.kind == KIND_LOAD) ? ST_MAG : ST_RD;
      end
      ST_MAG:  state_nxt = ST_SQ;
      ST_RD:   state_nxt = ST_SQ;
      ST_SQ:   state_nxt = (req_r.kind == KIND_LOAD) ? ST_IDLE : ST_THR;
      ST_THR:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_OUT;
      ST_OUT:  if (job_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      peak_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SQ && req_r.kind == KIND_LOAD && in_range_r &&
          (req_r.bin_index == '0 || mag_sum > peak_r)) begin
        peak_r <= mag_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r      <= in_data;
      in_range_r <= ({{(32-IDX_W){1'b0}}, in_data.bin_index} < 32'(BINS));
    end
    if (state_r == ST_MAG || state_r == ST_RD) begin
      sq_re_r <= MAG_W'(kr * kr);
      sq_im_r <= MAG_W'(ki * ki);
      if (req_r.kind == KIND_READ) begin
        job_data.a <= $signed(sig_rd[2*DATA_W-1:DATA_W]);
        job_data.b <= $signed(sig_rd[DATA_W-1:0]);
        job_data.c <= kr;
        job_data.d <= ki;
      end
      thr_sq_r <= threshold * threshold;
    end
    if (state_r == ST_SQ) begin
      mag_r    <= mag_sum;
      rhs_hi_r <= 56'(thr_sq_r * peak_r[MAG_W-1:24]);
    end
    if (state_r == ST_THR) begin
      rhs_r <= {rhs_hi_r, 24'd0} + {24'd0, 56'(thr_sq_r * peak_r[23:0])};
    end
    if (state_r == ST_CMP) begin
      job_data.res_index <= req_r.bin_index;
      job_data.pass      <= in_range_r && ({8'd0, mag_r, 24'd0} > rhs_r);
      job_data.mag       <= mag_r;
    end
  end

  assign job_valid = (state_r == ST_OUT);
endmodule

FILE: rtl/scdt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module scdt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s_valid,
  output logic            s_ready,
  input  scdt_pkg::job_t  s_data,
  output logic            m_valid,
  input  logic            m_ready,
  output scdt_pkg::job_t  m_data
);
  import scdt_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign s_ready = (cnt_r != 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign m_data  = mem_r[rp_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= s_data;
  end
endmodule

FILE: rtl/scdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_back
// Computes one result: complex multiply, or complex divide through a
// restoring radix-2 divider, then rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module scdt_back #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mode,
  input  logic               job_valid,
  output logic               job_ready,
  input  scdt_pkg::job_t     job_data,
  output logic               out_valid,
  input  logic               out_ready,
  output scdt_pkg::out_item_t out_data
);
  import scdt_pkg::*;

  localparam int QB   = 32 + FRAC_BITS;   // quotient bits kept
  localparam int NW   = 49;               // numerator magnitude width
  localparam int SH_W = NW + FRAC_BITS;   // shifted numerator width
  localparam int CW   = $clog2(SH_W + 1);
  localparam logic [NW-1:0] HALF = (FRAC_BITS > 0) ? NW'(1) << (FRAC_BITS > 0 ? FRAC_BITS-1 : 0)
                                                   : '0;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_P1   = 4'd1;
  localparam logic [3:0] ST_P2   = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_DFIN = 4'd4;
  localparam logic [3:0] ST_SAT  = 4'd5;
  localparam logic [3:0] ST_OUT  = 4'd6;

  logic [3:0] state_r, state_nxt;
  job_t       job_r;
  logic       mode_r;
  logic signed [NW-1:0] ac_r, bd_r, ad_r, bc_r;
  logic signed [NW-1:0] num_re, num_im;
  logic [NW-1:0]        m_im_r;
  logic                 n_re_r, n_im_r;
  logic                 part_r;           // 0 real, 1 imaginary
  logic [SH_W-1:0]      dvd_r;
  logic [MAG_W:0]       rem_r;
  logic [SH_W-1:0]      quo_r;
  logic [CW-1:0]        cnt_r;
  logic [QB+1:0]        q_re_r, q_im_r;
  logic [MAG_W:0]       rem_try;

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  assign num_re = (mode_r == MODE_MUL) ? ac_r - bd_r : ac_r + bd_r;
  assign num_im = (mode_r == MODE_MUL) ? ad_r + bc_r : bc_r - ad_r;

  function automatic logic [NW-1:0] absv(input logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  assign rem_try = {rem_r[MAG_W-1:0], dvd_r[SH_W-1]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = (mode_r == MODE_DIV && job_r.pass) ? ST_DIV : ST_SAT;
      ST_DIV:  if (cnt_r == CW'(SH_W - 1)) state_nxt = ST_DFIN;
      ST_DFIN: state_nxt = part_r ? ST_SAT : ST_DIV;
      ST_SAT:  state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  function automatic logic clp(input logic [QB+1:0] m, input logic n);
    return n ? (m > (QB+2)'(33'h080000000)) : (m > (QB+2)'(33'h07FFFFFFF));
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic [QB+1:0] m, input logic n);
    logic [OUT_W-1:0] v;
    if (n) v = clp(m, n) ? 32'h80000000 : OUT_W'(-m);
    else   v = clp(m, n) ? 32'h7FFFFFFF : OUT_W'(m);
    return v;
  endfunction

  function automatic logic [QB+1:0] rnd_q(input logic [SH_W-1:0] q,
                                           input logic [MAG_W:0] r,
                                           input logic [MAG_W-1:0] den);
    logic [SH_W-1:0] qq;
    qq = q;
    if (r >= ({1'b0, den} - r)) qq = q + SH_W'(1);
    return (qq > SH_W'(64'h0FFFFFFFF) << FRAC_BITS) ? (QB+2)'(1) << QB : (QB+2)'(qq);
  endfunction

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (job_valid) begin
        job_r  <= job_data;
        mode_r <= mode;
      end
      ST_P1: begin
        ac_r <= NW'(job_r.a * job_r.c);
        bd_r <= NW'(job_r.b * job_r.d);
        ad_r <= NW'(job_r.a * job_r.d);
        bc_r <= NW'(job_r.b * job_r.c);
      end
      ST_P2: begin
        m_im_r <= absv(num_im);
        n_re_r <= num_re[NW-1];
        n_im_r <= num_im[NW-1];
        part_r <= 1'b0;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        dvd_r  <= {absv(num_re), {FRAC_BITS{1'b0}}};
        q_re_r <= (QB+2)'((absv(num_re) + HALF) >> FRAC_BITS);
        q_im_r <= (QB+2)'((absv(num_im) + HALF) >> FRAC_BITS);
      end
      ST_DIV: begin
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + CW'(1);
        if (rem_try >= {1'b0, job_r.mag}) begin
          rem_r <= rem_try - {1'b0, job_r.mag};
          quo_r <= {quo_r[SH_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_try;
          quo_r <= {quo_r[SH_W-2:0], 1'b0};
        end
      end
      ST_DFIN: begin
        if (!part_r) q_re_r <= rnd_q(quo_r, rem_r, job_r.mag);
        else         q_im_r <= rnd_q(quo_r, rem_r, job_r.mag);
        part_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        dvd_r  <= {m_im_r, {FRAC_BITS{1'b0}}};
      end
      ST_SAT: begin
        out_data.res_index <= job_r.res_index;
        out_data.gated     <= ~job_r.pass;
        if (!job_r.pass) begin
          out_data.out_re  <= '0;
          out_data.out_im  <= '0;
          out_data.clipped <= 1'b0;
        end else begin
          out_data.out_re  <= sat(q_re_r, n_re_r);
          out_data.out_im  <= sat(q_im_r, n_im_r);
          out_data.clipped <= clp(q_re_r, n_re_r) | clp(q_im_r, n_im_r);
        end
      end
      default: ;
    endcase
  end
endmodule

FILE: rtl/spectral_conv_deconv_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_conv_deconv_threshold
// Per-bin spectral multiply/divide with relative kernel-magnitude gating.
// ----------------------------------------------------------------------------
// Channels: in_* carries requests (kind 0 stores a signal/kernel bin pair,
// kind 1 asks for one result bin); out_* returns one result per read request;
// cfg_* writes threshold (index 0, Q4.12) and mode (index 1, 0 mul, 1 div).
// A load of bin 0 restarts the running kernel peak.
// Front end: takes a request only while idle. A load passes the magnitude
// and squaring states; a read fetches operands and evaluates the gate in the
// read, square, threshold and compare states, then waits until a two-entry
// queue has room.
// Back end: takes a job only while idle and holds its result until out_ready.
// After products and sums, a job in divide mode that passed the gate runs the
// radix-2 divider for 49+FRAC_BITS steps per part, real part then imaginary.
// Reset clears state, peak, threshold and mode; the stores need no clearing.
// When out_ready is low the result holds in its output register while the
// front end keeps taking requests until a read finds the queue full.
// ----------------------------------------------------------------------------
module spectral_conv_deconv_threshold #(
  parameter int BINS      = 1024,
  parameter int FRAC_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  scdt_stream_if.sink   in_ch,
  scdt_stream_if.source out_ch,
  scdt_cfg_if.sink      cfg_ch
);
  import scdt_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic             mode_r;
  logic             job_valid, job_ready, q_valid, q_ready;
  job_t             job_data, q_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      mode_r      <= MODE_MUL;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_THRESHOLD: threshold_r <= cfg_ch.data;
        REG_MODE:      mode_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  scdt_front #(.BINS(BINS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .threshold(threshold_r),
    .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data));

  scdt_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .s_valid(job_valid), .s_ready(job_ready), .s_data(job_data),
    .m_valid(q_valid), .m_ready(q_ready), .m_data(q_data));

  scdt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r),
    .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

FILE: rtl/scdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scdt_checker
// Port-level checks of the result channel.
// ----------------------------------------------------------------------------
module scdt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input scdt_pkg::out_item_t out_data
);
  import scdt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_gate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gated |-> out_data.out_re == '0 && out_data.out_im == '0)
    else $error("gated result not zero");

  a_gate_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gated |-> !out_data.clipped)
    else $error("gated result flagged clipped");
endmodule

bind spectral_conv_deconv_threshold scdt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data));
